FILE: hw/rtl/coset_table_canonical_compare_top_macros.svh
// assertion macros for the coset table compare block
`ifndef COSET_TABLE_CANONICAL_COMPARE_TOP_MACROS_SVH
`define COSET_TABLE_CANONICAL_COMPARE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CTCC_ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("ctcc assertion failed");
`define CTCC_ASSERT(label, prop) `CTCC_ASSERT_CLK(label, aclk, aresetn, prop)
`else
`define CTCC_ASSERT_CLK(label, clk, rstn, prop)
`define CTCC_ASSERT(label, prop)
`endif
`endif

FILE: hw/rtl/ctcc_pkg.sv
// shared types, codes and column mapping for the coset table compare block
`default_nettype none
package ctcc_pkg;

    localparam int ENTRY_W = 11;

    typedef logic [6:0] col_t;

    typedef enum logic [1:0] {
        VERDICT_LESS     = 2'd0,
        VERDICT_EQUAL    = 2'd1,
        VERDICT_GREATER  = 2'd2,
        VERDICT_FEW_COLS = 2'd3
    } verdict_t;

    localparam logic [2:0] MODE_D    = 3'd0;
    localparam logic [2:0] MODE_DD   = 3'd1;
    localparam logic [2:0] MODE_C    = 3'd2;
    localparam logic [2:0] MODE_MIX1 = 3'd3;
    localparam logic [2:0] MODE_MIX2 = 3'd4;
    localparam logic [2:0] MODE_MIX3 = 3'd5;
    localparam logic [2:0] MODE_MIX5 = 3'd6;
    localparam logic [2:0] MODE_MIX6 = 3'd7;

    localparam logic [1:0] CFG_MODE = 2'd0;
    localparam logic [1:0] CFG_ROWS = 2'd1;
    localparam logic [1:0] CFG_COLS = 2'd2;

    typedef struct packed {
        logic     valid;
        verdict_t verdict;
    } walk_result_t;

    function automatic col_t cols_needed(input logic [2:0] mode);
        col_t n;
        case (mode)
            MODE_D:    n = 7'd5;
            MODE_DD:   n = 7'd4;
            MODE_C:    n = 7'd4;
            MODE_MIX1: n = 7'd3;
            MODE_MIX2: n = 7'd3;
            MODE_MIX3: n = 7'd5;
            MODE_MIX5: n = 7'd5;
            default:   n = 7'd7;
        endcase
        return n;
    endfunction

    function automatic col_t swap_pair(input col_t c, input col_t a, input col_t b);
        col_t r;
        r = c;
        if (c == a) begin
            r = b;
        end else if (c == b) begin
            r = a;
        end
        return r;
    endfunction

    function automatic col_t col_src(input logic [2:0] mode, input col_t c);
        col_t r;
        case (mode)
            MODE_D:    r = swap_pair(swap_pair(c, 7'd1, 7'd2), 7'd3, 7'd4);
            MODE_DD:   r = swap_pair(swap_pair(c, 7'd0, 7'd1), 7'd2, 7'd3);
            MODE_C:    r = swap_pair(swap_pair(c, 7'd0, 7'd2), 7'd1, 7'd3);
            MODE_MIX1: r = swap_pair(c, 7'd0, 7'd2);
            MODE_MIX3: r = swap_pair(c, 7'd2, 7'd4);
            MODE_MIX6: r = swap_pair(c, 7'd4, 7'd6);
            default:   r = c;
        endcase
        return r;
    endfunction

    // column taken through a two step product
    function automatic logic is_mixed(input logic [2:0] mode, input col_t c);
        return ((mode == MODE_MIX2) && (c == 7'd2)) || ((mode == MODE_MIX5) && (c == 7'd4));
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/coset_table_canonical_compare_top.sv
// top level of the coset table canonical compare block
// A coset table is loaded one entry per cycle, row-major, until the request
// flagged last; the block then checks it and returns one verdict (less, equal,
// greater, or too few columns for the mode). Loading runs at one entry per
// cycle. A mode with too few columns skips the check: the walk goes straight
// to its done state and the verdict is then registered at the output.
// Otherwise the check first clears row_count words of the coset memory, one
// per cycle, then walks every row once to relabel and once to compare. The
// work per table position is set by the single-read table memory, the
// two-step product of modes 4 and 6, and the read-modify-write of the coset
// memory. The compare stops early at the first differing entry. When the walk
// runs dry on a table that is not connected, each restart scans the cosets
// from coset 0. No request is taken while a check is running; a finished
// verdict waits in the output register while the next table loads.
`default_nettype none
`include "coset_table_canonical_compare_top_macros.svh"
module coset_table_canonical_compare_top #(
    parameter int MAX_ROWS = 2048,
    parameter int MAX_COLUMNS = 32
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [ctcc_pkg::ENTRY_W-1:0] s_entry,
    input  wire logic                         s_last,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [1:0]                   m_verdict,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [11:0]                  cfg_data
);
    import ctcc_pkg::*;

    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int COL_CW = $clog2(MAX_COLUMNS + 1);
    localparam int TBL_AW = $clog2(MAX_ROWS * MAX_COLUMNS);

    logic [2:0]         mode_reg;
    logic [ROW_CW-1:0]  nrows_reg;
    logic [COL_CW-1:0]  ncols_reg;
    logic               m_valid_reg;
    verdict_t           m_verdict_reg;
    logic               walk_idle;
    walk_result_t       walk_res;
    logic               res_ready;
    logic               in_accept;
    logic               tb_rd_en;
    logic [TBL_AW-1:0]  tb_rd_addr;
    logic [ENTRY_W-1:0] tb_rdata;

    assign cfg_ready = 1'b1;
    assign s_ready   = walk_idle;
    assign in_accept = s_valid && s_ready;
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_D;
            nrows_reg <= ROW_CW'(1);
            ncols_reg <= COL_CW'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_MODE: begin
                    mode_reg <= cfg_data[2:0];
                end
                CFG_ROWS: begin
                    if (cfg_data == '0) begin
                        nrows_reg <= ROW_CW'(1);
                    end else if (32'(cfg_data) > 32'(MAX_ROWS)) begin
                        nrows_reg <= ROW_CW'(MAX_ROWS);
                    end else begin
                        nrows_reg <= ROW_CW'(cfg_data);
                    end
                end
                CFG_COLS: begin
                    if (cfg_data[5:0] == '0) begin
                        ncols_reg <= COL_CW'(1);
                    end else if (32'(cfg_data[5:0]) > 32'(MAX_COLUMNS)) begin
                        ncols_reg <= COL_CW'(MAX_COLUMNS);
                    end else begin
                        ncols_reg <= COL_CW'(cfg_data[5:0]);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (walk_res.valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (walk_res.valid && res_ready) begin
            m_verdict_reg <= walk_res.verdict;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_verdict = m_verdict_reg;

    ctcc_table #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld_en    (in_accept),
        .ld_entry (s_entry),
        .ld_last  (s_last),
        .rd_en    (tb_rd_en),
        .rd_addr  (tb_rd_addr),
        .rd_data  (tb_rdata)
    );

    ctcc_walk #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_walk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (in_accept && s_last),
        .mode       (mode_reg),
        .nrows      (nrows_reg),
        .ncols      (ncols_reg),
        .idle       (walk_idle),
        .res        (walk_res),
        .res_ready  (res_ready),
        .tb_rd_en   (tb_rd_en),
        .tb_rd_addr (tb_rd_addr),
        .tb_rdata   (tb_rdata)
    );

    `CTCC_ASSERT(a_start_busy, (s_valid && s_ready && s_last) |=> !walk_idle)
    `CTCC_ASSERT(a_result_hold, (walk_res.valid && !res_ready) |=> walk_res.valid && $stable(walk_res.verdict))
    `CTCC_ASSERT(a_out_from_walk, $rose(m_valid_reg) |-> $past(walk_res.valid))

endmodule
`default_nettype wire

FILE: hw/rtl/ctcc_table.sv
// table store memory with its load position counter
`default_nettype none
module ctcc_table #(
    parameter int MAX_ROWS = 2048,
    parameter int MAX_COLUMNS = 32,
    localparam int TBL_DEPTH = MAX_ROWS * MAX_COLUMNS,
    localparam int TBL_AW = $clog2(TBL_DEPTH),
    localparam int LOAD_CW = $clog2(TBL_DEPTH + 1)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         ld_en,
    input  wire logic [ctcc_pkg::ENTRY_W-1:0] ld_entry,
    input  wire logic                         ld_last,
    input  wire logic                         rd_en,
    input  wire logic [TBL_AW-1:0]            rd_addr,
    output logic      [ctcc_pkg::ENTRY_W-1:0] rd_data
);
    import ctcc_pkg::*;

    logic [ENTRY_W-1:0] mem [TBL_DEPTH];
    logic [LOAD_CW-1:0] load_pos_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               wr_en;

    assign wr_en = ld_en && (load_pos_reg < LOAD_CW'(TBL_DEPTH));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_pos_reg <= '0;
        end else if (ld_en) begin
            if (ld_last) begin
                load_pos_reg <= '0;
            end else if (wr_en) begin
                load_pos_reg <= load_pos_reg + LOAD_CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[load_pos_reg[TBL_AW-1:0]] <= ld_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/ctcc_walk.sv
// sequencer for breadth-first relabel and lexicographic compare, with coset memory
`default_nettype none
module ctcc_walk #(
    parameter int MAX_ROWS = 2048,
    parameter int MAX_COLUMNS = 32,
    localparam int ROW_AW = $clog2(MAX_ROWS),
    localparam int ROW_CW = $clog2(MAX_ROWS + 1),
    localparam int COL_CW = $clog2(MAX_COLUMNS + 1),
    localparam int TBL_AW = $clog2(MAX_ROWS * MAX_COLUMNS)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [2:0]                   mode,
    input  wire logic [ROW_CW-1:0]            nrows,
    input  wire logic [COL_CW-1:0]            ncols,
    output logic                              idle,
    output ctcc_pkg::walk_result_t            res,
    input  wire logic                         res_ready,
    output logic                              tb_rd_en,
    output logic      [TBL_AW-1:0]            tb_rd_addr,
    input  wire logic [ctcc_pkg::ENTRY_W-1:0] tb_rdata
);
    import ctcc_pkg::*;

    localparam int VAL_W = (ENTRY_W > ROW_AW) ? ENTRY_W : ROW_AW;
    localparam int CW_W = 2 * ROW_AW + 1;
    localparam int PW = ROW_AW + COL_CW;

    typedef enum logic [18:0] {
        ST_IDLE    = 19'd1,
        ST_CLEAR   = 19'd2,
        ST_ROW     = 19'd4,
        ST_VIS     = 19'd8,
        ST_BASE    = 19'd16,
        ST_COL     = 19'd32,
        ST_AGET    = 19'd64,
        ST_XGET    = 19'd128,
        ST_X2RD    = 19'd256,
        ST_X2GET   = 19'd512,
        ST_BCHK    = 19'd1024,
        ST_LBL     = 19'd2048,
        ST_CMP     = 19'd4096,
        ST_SEEN    = 19'd8192,
        ST_SCANRD  = 19'd16384,
        ST_SCANCHK = 19'd32768,
        ST_PUSH1   = 19'd65536,
        ST_PUSH2   = 19'd131072,
        ST_DONE    = 19'd262144
    } state_t;

    state_t              state_reg;
    logic [ROW_CW-1:0]   i_reg;
    logic [ROW_CW-1:0]   k_reg;
    logic [ROW_CW-1:0]   u_reg;
    logic [COL_CW-1:0]   j_reg;
    logic [ROW_AW-1:0]   cur_reg;
    logic [TBL_AW-1:0]   base_reg;
    logic [TBL_AW-1:0]   abase_reg;
    logic [TBL_AW-1:0]   base2_reg;
    logic [ENTRY_W-1:0]  a_reg;
    logic [VAL_W-1:0]    b_reg;
    logic                cmp_reg;
    logic                scan_reg;
    verdict_t            verdict_reg;

    // coset memory word: seen, new label, visit order slot
    logic [CW_W-1:0]     cmem [MAX_ROWS];
    logic [CW_W-1:0]     cm_rdata_reg;
    logic                cm_rd_en;
    logic [ROW_AW-1:0]   cm_rd_addr;
    logic                cm_wr_en;
    logic [ROW_AW-1:0]   cm_wr_addr;
    logic [CW_W-1:0]     cm_wr_data;

    logic                rd_seen;
    logic [ROW_AW-1:0]   rd_label;
    logic [ROW_AW-1:0]   rd_visit;
    logic [COL_CW-1:0]   j_src;
    logic                j_mixed;
    logic                b_in;
    logic                x_in;
    logic                k_room;
    logic                fwd_hit;

    assign rd_seen  = cm_rdata_reg[CW_W-1];
    assign rd_label = cm_rdata_reg[2*ROW_AW-1:ROW_AW];
    assign rd_visit = cm_rdata_reg[ROW_AW-1:0];
    assign j_src    = COL_CW'(col_src(mode, col_t'(j_reg)));
    assign j_mixed  = is_mixed(mode, col_t'(j_reg));
    assign b_in     = 32'(b_reg) < 32'(nrows);
    assign x_in     = 32'(tb_rdata) < 32'(nrows);
    assign k_room   = k_reg < nrows;
    assign fwd_hit  = b_reg[ROW_AW-1:0] == k_reg[ROW_AW-1:0];

    function automatic logic [TBL_AW-1:0] row_base(input logic [ROW_AW-1:0] r,
                                                   input logic [COL_CW-1:0] n);
        logic [PW-1:0] p;
        p = PW'(r) * PW'(n);
        return p[TBL_AW-1:0];
    endfunction

    always_comb begin
        cm_rd_en   = 1'b0;
        cm_rd_addr = i_reg[ROW_AW-1:0];
        cm_wr_en   = 1'b0;
        cm_wr_addr = u_reg[ROW_AW-1:0];
        cm_wr_data = '0;
        tb_rd_en   = 1'b0;
        tb_rd_addr = base_reg + TBL_AW'(j_src);
        unique case (state_reg)
            ST_CLEAR: begin
                cm_wr_en = 1'b1;
                if (u_reg == '0) begin
                    cm_wr_data = {1'b1, {(2 * ROW_AW){1'b0}}};
                end
            end
            ST_ROW: begin
                cm_rd_en = 1'b1;
            end
            ST_COL: begin
                tb_rd_en = 1'b1;
                if (cmp_reg) begin
                    tb_rd_addr = abase_reg + TBL_AW'(j_reg);
                end
            end
            ST_AGET: begin
                tb_rd_en = 1'b1;
            end
            ST_X2RD: begin
                tb_rd_en   = 1'b1;
                tb_rd_addr = base2_reg + TBL_AW'(1);
            end
            ST_BCHK: begin
                cm_rd_en   = 1'b1;
                cm_rd_addr = b_reg[ROW_AW-1:0];
            end
            ST_SCANRD: begin
                cm_rd_en   = 1'b1;
                cm_rd_addr = u_reg[ROW_AW-1:0];
            end
            ST_PUSH1: begin
                cm_rd_en   = 1'b1;
                cm_rd_addr = k_reg[ROW_AW-1:0];
                cm_wr_en   = 1'b1;
                cm_wr_addr = b_reg[ROW_AW-1:0];
                cm_wr_data = {1'b1, k_reg[ROW_AW-1:0], rd_visit};
            end
            ST_PUSH2: begin
                cm_wr_en   = 1'b1;
                cm_wr_addr = k_reg[ROW_AW-1:0];
                if (fwd_hit) begin
                    cm_wr_data = {1'b1, k_reg[ROW_AW-1:0], b_reg[ROW_AW-1:0]};
                end else begin
                    cm_wr_data = {rd_seen, rd_label, b_reg[ROW_AW-1:0]};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cm_wr_en) begin
            cmem[cm_wr_addr] <= cm_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cm_rd_en) begin
            cm_rdata_reg <= cmem[cm_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cmp_reg   <= 1'b0;
            scan_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        if (col_t'(ncols) < cols_needed(mode)) begin
                            verdict_reg <= VERDICT_FEW_COLS;
                            state_reg   <= ST_DONE;
                        end else begin
                            u_reg     <= '0;
                            state_reg <= ST_CLEAR;
                        end
                    end
                end
                ST_CLEAR: begin
                    if (u_reg + ROW_CW'(1) == nrows) begin
                        k_reg     <= ROW_CW'(1);
                        i_reg     <= '0;
                        cmp_reg   <= 1'b0;
                        state_reg <= ST_ROW;
                    end else begin
                        u_reg <= u_reg + ROW_CW'(1);
                    end
                end
                ST_ROW: begin
                    if (i_reg == nrows) begin
                        if (cmp_reg) begin
                            verdict_reg <= VERDICT_EQUAL;
                            state_reg   <= ST_DONE;
                        end else begin
                            cmp_reg <= 1'b1;
                            i_reg   <= '0;
                        end
                    end else if (!cmp_reg && (i_reg >= k_reg)) begin
                        u_reg     <= '0;
                        state_reg <= ST_SCANRD;
                    end else begin
                        state_reg <= ST_VIS;
                    end
                end
                ST_VIS: begin
                    cur_reg   <= rd_visit;
                    abase_reg <= row_base(i_reg[ROW_AW-1:0], ncols);
                    state_reg <= ST_BASE;
                end
                ST_BASE: begin
                    base_reg  <= row_base(cur_reg, ncols);
                    j_reg     <= '0;
                    state_reg <= ST_COL;
                end
                ST_COL: begin
                    if (j_reg == ncols) begin
                        i_reg     <= i_reg + ROW_CW'(1);
                        state_reg <= ST_ROW;
                    end else if (cmp_reg) begin
                        state_reg <= ST_AGET;
                    end else begin
                        state_reg <= ST_XGET;
                    end
                end
                ST_AGET: begin
                    a_reg     <= tb_rdata;
                    state_reg <= ST_XGET;
                end
                ST_XGET: begin
                    if (j_mixed && x_in) begin
                        base2_reg <= row_base(ROW_AW'(tb_rdata), ncols);
                        state_reg <= ST_X2RD;
                    end else begin
                        b_reg     <= VAL_W'(tb_rdata);
                        state_reg <= ST_BCHK;
                    end
                end
                ST_X2RD: begin
                    state_reg <= ST_X2GET;
                end
                ST_X2GET: begin
                    b_reg     <= VAL_W'(tb_rdata);
                    state_reg <= ST_BCHK;
                end
                ST_BCHK: begin
                    if (cmp_reg) begin
                        state_reg <= b_in ? ST_LBL : ST_CMP;
                    end else if (b_in && k_room) begin
                        state_reg <= ST_SEEN;
                    end else begin
                        j_reg     <= j_reg + COL_CW'(1);
                        state_reg <= ST_COL;
                    end
                end
                ST_LBL: begin
                    b_reg     <= VAL_W'(rd_label);
                    state_reg <= ST_CMP;
                end
                ST_CMP: begin
                    if (32'(a_reg) < 32'(b_reg)) begin
                        verdict_reg <= VERDICT_LESS;
                        state_reg   <= ST_DONE;
                    end else if (32'(a_reg) > 32'(b_reg)) begin
                        verdict_reg <= VERDICT_GREATER;
                        state_reg   <= ST_DONE;
                    end else begin
                        j_reg     <= j_reg + COL_CW'(1);
                        state_reg <= ST_COL;
                    end
                end
                ST_SEEN: begin
                    if (rd_seen) begin
                        j_reg     <= j_reg + COL_CW'(1);
                        state_reg <= ST_COL;
                    end else begin
                        scan_reg  <= 1'b0;
                        state_reg <= ST_PUSH1;
                    end
                end
                ST_SCANRD: begin
                    state_reg <= ST_SCANCHK;
                end
                ST_SCANCHK: begin
                    if (rd_seen) begin
                        if (u_reg + ROW_CW'(1) >= nrows) begin
                            cmp_reg   <= 1'b1;
                            i_reg     <= '0;
                            state_reg <= ST_ROW;
                        end else begin
                            u_reg     <= u_reg + ROW_CW'(1);
                            state_reg <= ST_SCANRD;
                        end
                    end else begin
                        b_reg     <= VAL_W'(u_reg);
                        scan_reg  <= 1'b1;
                        state_reg <= ST_PUSH1;
                    end
                end
                ST_PUSH1: begin
                    state_reg <= ST_PUSH2;
                end
                ST_PUSH2: begin
                    k_reg <= k_reg + ROW_CW'(1);
                    if (scan_reg) begin
                        cur_reg   <= b_reg[ROW_AW-1:0];
                        state_reg <= ST_BASE;
                    end else begin
                        j_reg     <= j_reg + COL_CW'(1);
                        state_reg <= ST_COL;
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign idle        = state_reg == ST_IDLE;
    assign res.valid   = state_reg == ST_DONE;
    assign res.verdict = verdict_reg;

endmodule
`default_nettype wire
